// ===== hw/rtl/icv_pkg.sv =====
// ----------------------------------------------------------------------------
// icv_pkg
// shared types and constants of the impulse response convolver
// ----------------------------------------------------------------------------
package icv_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int FUNC_BITS      = 2;
    localparam int COEF_IDX_BITS  = 10;
    localparam int TAP_COUNT_BITS = 11;

    localparam logic [FUNC_BITS-1:0] FUNC_WR_COEF = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_SAMPLE  = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_CLEAR   = 2'd2;

    typedef struct packed {
        logic clr;
        logic vld;
        logic last;
        logic hist_ok;
    } mac_ctl_t;

endpackage

// ===== hw/rtl/icv_store.sv =====
// ----------------------------------------------------------------------------
// icv_store
// coefficient memory and sample history memory, one write and one registered
// read port each
// ----------------------------------------------------------------------------
module icv_store #(
    parameter int MAX_TAPS = 1024
) (
    input  logic                                clk,
    input  logic                                coef_we,
    input  logic [$clog2(MAX_TAPS)-1:0]         coef_waddr,
    input  logic [icv_pkg::SAMPLE_BITS-1:0]     coef_wdata,
    input  logic [$clog2(MAX_TAPS)-1:0]         coef_raddr,
    output logic [icv_pkg::SAMPLE_BITS-1:0]     coef_rdata,
    input  logic                                hist_we,
    input  logic [$clog2(MAX_TAPS)-1:0]         hist_waddr,
    input  logic [icv_pkg::SAMPLE_BITS-1:0]     hist_wdata,
    input  logic [$clog2(MAX_TAPS)-1:0]         hist_raddr,
    output logic [icv_pkg::SAMPLE_BITS-1:0]     hist_rdata
);

    logic [icv_pkg::SAMPLE_BITS-1:0] coef_mem [MAX_TAPS];
    logic [icv_pkg::SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];

    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_mem[coef_waddr] <= coef_wdata;
        end
        coef_rdata <= coef_mem[coef_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        hist_rdata <= hist_mem[hist_raddr];
    end

endmodule

// ===== hw/rtl/icv_mac.sv =====
// ----------------------------------------------------------------------------
// icv_mac
// multiply-accumulate pipeline with rounding and saturation of the sum
// ----------------------------------------------------------------------------
module icv_mac #(
    parameter int MAX_TAPS = 1024
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  icv_pkg::mac_ctl_t                       ctl,
    input  logic signed [icv_pkg::SAMPLE_BITS-1:0]  coef,
    input  logic signed [icv_pkg::SAMPLE_BITS-1:0]  hist,
    output logic                                    done,
    output logic [icv_pkg::SAMPLE_BITS-1:0]         res_sample,
    output logic                                    res_sat
);

    localparam int SW    = icv_pkg::SAMPLE_BITS;
    localparam int PW    = 2 * SW;
    localparam int ACC_W = PW + $clog2(MAX_TAPS) + 1;

    icv_pkg::mac_ctl_t         ctl1_reg;
    icv_pkg::mac_ctl_t         ctl2_reg;
    logic signed [PW-1:0]      prod_reg;
    logic signed [PW-1:0]      prod_next;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic                      done_reg;
    logic                      done_next;
    logic signed [ACC_W-1:0]   rnd_sum;
    logic signed [ACC_W-1:0]   q;
    logic                      over_pos;
    logic                      over_neg;

    // stage 1 lines up with the memory read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctl1_reg <= ctl;
            ctl2_reg <= ctl1_reg;
            done_reg <= done_next;
        end
    end

    always_comb
    begin
        prod_next = '0;
        if (ctl1_reg.hist_ok)
        begin
            prod_next = coef * hist;
        end
    end

    always_comb
    begin
        acc_next  = acc_reg;
        done_next = done_reg;
        if (ctl.clr)
        begin
            acc_next  = '0;
            done_next = 1'b0;
        end
        else if (ctl2_reg.vld)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
            if (ctl2_reg.last)
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    // round half up, shift back to q1.23, saturate
    always_comb
    begin
        rnd_sum  = acc_reg + (ACC_W'(1) <<< (SW - 2));
        q        = rnd_sum >>> (SW - 1);
        over_pos = !q[ACC_W-1] && (|q[ACC_W-2:SW-1]);
        over_neg = q[ACC_W-1] && !(&q[ACC_W-2:SW-1]);
        res_sat  = over_pos || over_neg;
        if (over_pos)
        begin
            res_sample = {1'b0, {(SW-1){1'b1}}};
        end
        else if (over_neg)
        begin
            res_sample = {1'b1, {(SW-1){1'b0}}};
        end
        else
        begin
            res_sample = q[SW-1:0];
        end
    end

    assign done = done_reg;

endmodule

// ===== hw/rtl/impulse_response_convolver_top.sv =====
// ----------------------------------------------------------------------------
// impulse_response_convolver_top
// direct-form convolution of a sample stream with a stored impulse response
// ----------------------------------------------------------------------------
// A sample word is worked through tap by tap, in turn, as the coefficient
// and history memories each have a single read port feeding one multiplier;
// behind the reads come multiply, accumulate and output stages. Coefficient
// writes and history clears leave the block in its idle state. A clear needs
// no sweep: a fill count masks history slots not written since the clear.
// The next word is taken once the result sits in the output register, even
// while that result still waits to be taken.
module impulse_response_convolver_top #(
    parameter int MAX_TAPS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata,      // tap_count
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // coef_index, coef_value, in_sample, zero pad
    input  logic [1:0]  s_axis_tuser,   // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // out_sample
    output logic        m_axis_tuser    // saturated
);

    localparam int SW = icv_pkg::SAMPLE_BITS;
    localparam int AW = $clog2(MAX_TAPS);
    localparam int TW = $clog2(MAX_TAPS + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]                             state_reg, state_next;
    logic [AW-1:0]                          k_reg, k_next;
    logic [AW-1:0]                          pos_reg, pos_next;
    logic [AW-1:0]                          ptr_reg, ptr_next;
    logic [TW-1:0]                          fill_reg, fill_next;
    logic [TW-1:0]                          taps_reg, taps_next;
    logic [icv_pkg::TAP_COUNT_BITS-1:0]     tap_count_reg;
    logic                                   m_valid_reg, m_valid_next;
    logic [SW-1:0]                          m_data_reg;
    logic                                   m_sat_reg;
    logic                                   out_load;

    logic [icv_pkg::FUNC_BITS-1:0]          func;
    logic [icv_pkg::COEF_IDX_BITS-1:0]      coef_index;
    logic [SW-1:0]                          coef_value;
    logic [SW-1:0]                          in_sample;
    logic                                   accept;
    logic                                   coef_we;
    logic                                   hist_we;
    logic                                   last_tap;
    logic [TW-1:0]                          eff_taps;

    logic [SW-1:0]                          coef_rdata;
    logic [SW-1:0]                          hist_rdata;
    icv_pkg::mac_ctl_t                      mac_ctl;
    logic                                   mac_done;
    logic [SW-1:0]                          res_sample;
    logic                                   res_sat;

    assign func       = s_axis_tuser;
    assign coef_index = s_axis_tdata[9:0];
    assign coef_value = s_axis_tdata[33:10];
    assign in_sample  = s_axis_tdata[57:34];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign coef_we = accept && (func == icv_pkg::FUNC_WR_COEF)
                     && (32'(coef_index) < 32'(MAX_TAPS));
    assign hist_we = accept && (func == icv_pkg::FUNC_SAMPLE);

    always_comb
    begin
        if (tap_count_reg == '0)
        begin
            eff_taps = TW'(1);
        end
        else if (32'(tap_count_reg) > 32'(MAX_TAPS))
        begin
            eff_taps = TW'(MAX_TAPS);
        end
        else
        begin
            eff_taps = TW'(tap_count_reg);
        end
    end

    assign last_tap = (TW'(k_reg) == (taps_reg - TW'(1)));
    assign out_load = (state_reg == ST_DRAIN) && mac_done
                      && (!m_valid_reg || m_axis_tready);

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        pos_next   = pos_reg;
        ptr_next   = ptr_reg;
        fill_next  = fill_reg;
        taps_next  = taps_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (func)
                        icv_pkg::FUNC_SAMPLE:
                        begin
                            state_next = ST_RUN;
                            k_next     = '0;
                            pos_next   = ptr_reg;
                            taps_next  = eff_taps;
                            ptr_next   = (ptr_reg == AW'(MAX_TAPS - 1)) ? '0
                                                                        : ptr_reg + AW'(1);
                            if (fill_reg != TW'(MAX_TAPS))
                            begin
                                fill_next = fill_reg + TW'(1);
                            end
                        end
                        icv_pkg::FUNC_CLEAR:
                        begin
                            ptr_next  = '0;
                            fill_next = '0;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                k_next   = k_reg + AW'(1);
                pos_next = (pos_reg == '0) ? AW'(MAX_TAPS - 1) : pos_reg - AW'(1);
                if (last_tap)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mac_ctl.clr     = hist_we;
        mac_ctl.vld     = (state_reg == ST_RUN);
        mac_ctl.last    = last_tap;
        mac_ctl.hist_ok = (TW'(k_reg) < fill_reg);
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (out_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            pos_reg       <= '0;
            ptr_reg       <= '0;
            fill_reg      <= '0;
            taps_reg      <= TW'(1);
            tap_count_reg <= icv_pkg::TAP_COUNT_BITS'(1);
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            pos_reg     <= pos_next;
            ptr_reg     <= ptr_next;
            fill_reg    <= fill_next;
            taps_reg    <= taps_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we)
            begin
                tap_count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_data_reg <= res_sample;
            m_sat_reg  <= res_sat;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_sat_reg;

    icv_store #(
        .MAX_TAPS (MAX_TAPS)
    ) u_store (
        .clk        (clk),
        .coef_we    (coef_we),
        .coef_waddr (AW'(coef_index)),
        .coef_wdata (coef_value),
        .coef_raddr (k_reg),
        .coef_rdata (coef_rdata),
        .hist_we    (hist_we),
        .hist_waddr (ptr_reg),
        .hist_wdata (in_sample),
        .hist_raddr (pos_reg),
        .hist_rdata (hist_rdata)
    );

    icv_mac #(
        .MAX_TAPS (MAX_TAPS)
    ) u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (mac_ctl),
        .coef       (coef_rdata),
        .hist       (hist_rdata),
        .done       (mac_done),
        .res_sample (res_sample),
        .res_sat    (res_sat)
    );

endmodule

// ===== bench/tb_impulse_response_convolver_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_impulse_response_convolver_top
// self-checking bench for the impulse response convolver: a clocked driver
// sends coefficient, sample, clear and unused words from a queue, a scoreboard
// model predicts each convolved output, and a clocked monitor compares every
// accepted output word against the oldest prediction
// ----------------------------------------------------------------------------
module tb_impulse_response_convolver_top;

    localparam int FUNC_BITS     = icv_pkg::FUNC_BITS;
    localparam int COEF_IDX_BITS = icv_pkg::COEF_IDX_BITS;
    localparam int SAMPLE_BITS   = icv_pkg::SAMPLE_BITS;

    localparam int MAX_TAPS = 1024;
    localparam int SETTLE_CYCLES = 16;
    localparam int END_CYCLES = 64;
    localparam int LONG_HOLD_CYCLES = 1500;
    localparam logic [FUNC_BITS-1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [FUNC_BITS-1:0]     func;
        logic [COEF_IDX_BITS-1:0] coef_index;
        logic [SAMPLE_BITS-1:0]   coef_value;
        logic [SAMPLE_BITS-1:0]   in_sample;
    } conv_word_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] out_sample;
        logic                   saturated;
    } conv_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [10:0] cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;   // coef_index, coef_value, in_sample, zero pad
    logic [1:0]  s_axis_tuser = '0;   // func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // out_sample
    logic        m_axis_tuser;        // saturated

    impulse_response_convolver_top #(
        .MAX_TAPS(MAX_TAPS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // scoreboard model state
    logic [SAMPLE_BITS-1:0] coef_mem [0:MAX_TAPS-1];
    logic [SAMPLE_BITS-1:0] hist_mem [0:MAX_TAPS-1];
    int unsigned            hist_wr_ptr = 0;
    logic [10:0]            taps_cfg = 11'd1;

    conv_word_t   pending_words [$];
    conv_result_t expected_outputs [$];
    bit           coef_planned [0:MAX_TAPS-1];

    int errors = 0;
    int n_samples = 0;
    int n_writes = 0;
    int n_clears = 0;
    int n_ignored = 0;
    int n_clipped = 0;
    int n_results = 0;
    int tap_settings = 0;

    int sender_mode = 1;
    int receiver_mode = 1;
    int hold_requests = 0;

    function automatic int effective_taps(input logic [10:0] t);
        if (t == 0)
            return 1;
        if (t > MAX_TAPS)
            return MAX_TAPS;
        return int'(t);
    endfunction

    function automatic conv_result_t convolve_sample(input logic [SAMPLE_BITS-1:0] x);
        conv_result_t r;
        longint acc;
        longint q;
        int taps;
        int pos;
        acc = 0;
        taps = effective_taps(taps_cfg);
        hist_mem[hist_wr_ptr] = x;
        pos = hist_wr_ptr;
        for (int k = 0; k < taps; k++)
        begin
            acc += longint'($signed(coef_mem[k])) * longint'($signed(hist_mem[pos]));
            pos = (pos == 0) ? MAX_TAPS - 1 : pos - 1;
        end
        // round half up, back to q1.23
        q = (acc + (longint'(1) <<< (SAMPLE_BITS - 2))) >>> (SAMPLE_BITS - 1);
        r.saturated = 1'b1;
        if (q > 64'sd8388607)
            r.out_sample = 24'h7FFFFF;
        else if (q < -64'sd8388608)
            r.out_sample = 24'h800000;
        else
        begin
            r.out_sample = q[SAMPLE_BITS-1:0];
            r.saturated = 1'b0;
        end
        hist_wr_ptr = (hist_wr_ptr + 1) % MAX_TAPS;
        return r;
    endfunction

    task automatic apply_word(input conv_word_t w);
        conv_result_t r;
        case (w.func)
            icv_pkg::FUNC_WR_COEF:
            begin
                coef_mem[w.coef_index] = w.coef_value;
                n_writes++;
            end
            icv_pkg::FUNC_SAMPLE:
            begin
                r = convolve_sample(w.in_sample);
                expected_outputs.push_back(r);
                n_samples++;
                if (r.saturated)
                    n_clipped++;
            end
            icv_pkg::FUNC_CLEAR:
            begin
                foreach (hist_mem[i])
                    hist_mem[i] = '0;
                hist_wr_ptr = 0;
                n_clears++;
            end
            default:
                n_ignored++;
        endcase
    endtask

    task automatic note_failure(input string msg);
        errors++;
        if (errors <= 10)
            $display("%t  MISMATCH  %s", $realtime, msg);
    endtask

    // driver: bursts with gaps, holds the word while tready is low
    conv_word_t word_on_bus;
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            burst_left = 1;
            gap_left = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                apply_word(word_on_bus);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_words.size() != 0)
                begin
                    word_on_bus = pending_words.pop_front();
                    s_axis_tdata <= {6'd0, word_on_bus.in_sample, word_on_bus.coef_value,
                                     word_on_bus.coef_index};
                    s_axis_tuser <= word_on_bus.func;
                    s_axis_tvalid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        case (sender_mode)
                            0:
                            begin
                                burst_left = 64;
                                gap_left = 0;
                            end
                            1:
                            begin
                                burst_left = $urandom_range(1, 8);
                                gap_left = $urandom_range(0, 4);
                            end
                            default:
                            begin
                                burst_left = $urandom_range(1, 3);
                                gap_left = $urandom_range(0, 20);
                            end
                        endcase
                    end
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor: checks output words, stalls on its own pattern
    conv_result_t want;
    int stall_left;
    int hold_left;
    int holds_served;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
            hold_left = 0;
            holds_served = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                n_results++;
                if (expected_outputs.size() == 0)
                    note_failure($sformatf("unexpected word out %h sat %b",
                                           m_axis_tdata, m_axis_tuser));
                else
                begin
                    want = expected_outputs.pop_front();
                    if (m_axis_tdata !== want.out_sample || m_axis_tuser !== want.saturated)
                        note_failure($sformatf("word %0d: expected %h sat %b, got %h sat %b",
                                               n_results, want.out_sample, want.saturated,
                                               m_axis_tdata, m_axis_tuser));
                end
            end
            if (hold_requests != holds_served)
            begin
                holds_served++;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (receiver_mode == 1 && $urandom_range(0, 99) < 30)
            begin
                stall_left = $urandom_range(0, 3);
                m_axis_tready <= 1'b0;
            end
            else if (receiver_mode == 2 && $urandom_range(0, 99) < 75)
            begin
                stall_left = $urandom_range(0, 12);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    function automatic logic [SAMPLE_BITS-1:0] random_q123(input int lo_shift,
                                                           input int hi_shift);
        logic [SAMPLE_BITS-1:0] v;
        v = SAMPLE_BITS'($urandom);
        v = SAMPLE_BITS'($signed(v) >>> $urandom_range(lo_shift, hi_shift));
        return v;
    endfunction

    task automatic queue_word(input logic [FUNC_BITS-1:0] func, input int idx,
                              input logic [SAMPLE_BITS-1:0] coef,
                              input logic [SAMPLE_BITS-1:0] smp);
        conv_word_t w;
        w.func = func;
        w.coef_index = COEF_IDX_BITS'(idx);
        w.coef_value = coef;
        w.in_sample = smp;
        if (func == icv_pkg::FUNC_WR_COEF)
            coef_planned[idx] = 1'b1;
        pending_words.push_back(w);
    endtask

    task automatic load_missing_coefs(input int taps);
        for (int k = 0; k < taps; k++)
            if (!coef_planned[k])
                queue_word(icv_pkg::FUNC_WR_COEF, k, random_q123(6, 16), random_q123(0, 0));
    endtask

    task automatic queue_random_words(input int taps, input int count);
        int pick;
        int idx;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 3) == 0)
                idx = $urandom_range(0, MAX_TAPS - 1);
            else
                idx = $urandom_range(0, (taps + 3 < MAX_TAPS) ? taps + 3 : MAX_TAPS - 1);
            if (pick < 55)
                queue_word(icv_pkg::FUNC_SAMPLE, $urandom_range(0, MAX_TAPS - 1),
                           random_q123(0, 23), random_q123(0, 14));
            else if (pick < 80)
                queue_word(icv_pkg::FUNC_WR_COEF, idx, random_q123(0, 14),
                           random_q123(0, 23));
            else if (pick < 92)
                queue_word(icv_pkg::FUNC_CLEAR, $urandom_range(0, MAX_TAPS - 1),
                           random_q123(0, 0), random_q123(0, 0));
            else
                queue_word(FUNC_UNUSED, $urandom_range(0, MAX_TAPS - 1), random_q123(0, 0),
                           random_q123(0, 0));
        end
    endtask

    task automatic wait_for_drain(input int extra);
        do
            @(negedge clk);
        while (pending_words.size() != 0 || s_axis_tvalid || expected_outputs.size() != 0);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_tap_count(input logic [10:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        taps_cfg = value;
        tap_settings++;
    endtask

    task automatic run_phase(input logic [10:0] taps, input int smode, input int rmode,
                             input int count, input bit long_hold);
        write_tap_count(taps);
        @(negedge clk);
        sender_mode = smode;
        receiver_mode = rmode;
        load_missing_coefs(effective_taps(taps));
        if (long_hold)
            hold_requests++;
        queue_random_words(effective_taps(taps), count);
        wait_for_drain(SETTLE_CYCLES);
    endtask

    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        foreach (coef_planned[i])
            coef_planned[i] = 1'b0;
        foreach (hist_mem[i])
            hist_mem[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // single tap at reset setting: extremes and half-lsb rounding
        sender_mode = 1;
        receiver_mode = 1;
        queue_word(icv_pkg::FUNC_WR_COEF, 0, 24'h7FFFFF, 24'h000000);
        queue_word(icv_pkg::FUNC_SAMPLE, 0, 24'h000000, 24'h7FFFFF);
        queue_word(icv_pkg::FUNC_SAMPLE, 0, 24'h000000, 24'h800000);
        queue_word(icv_pkg::FUNC_WR_COEF, 0, 24'h800000, 24'hFFFFFF);
        queue_word(icv_pkg::FUNC_SAMPLE, 0, 24'hFFFFFF, 24'h800000);
        queue_word(icv_pkg::FUNC_SAMPLE, 0, 24'h000000, 24'h7FFFFF);
        queue_word(icv_pkg::FUNC_WR_COEF, 0, 24'h000001, 24'h000000);
        queue_word(icv_pkg::FUNC_SAMPLE, 0, 24'h000000, 24'h400000);
        queue_word(icv_pkg::FUNC_SAMPLE, 0, 24'h000000, 24'hC00000);
        queue_word(icv_pkg::FUNC_SAMPLE, 1023, 24'hFFFFFF, 24'h000000);
        queue_word(FUNC_UNUSED, 1023, 24'hFFFFFF, 24'hFFFFFF);
        queue_word(icv_pkg::FUNC_WR_COEF, 1023, 24'h555555, 24'hAAAAAA);
        queue_word(icv_pkg::FUNC_WR_COEF, 1, 24'h800000, 24'h000000);
        queue_word(icv_pkg::FUNC_WR_COEF, 2, 24'h800000, 24'h000000);
        queue_word(icv_pkg::FUNC_WR_COEF, 0, 24'h800000, 24'h000000);
        wait_for_drain(SETTLE_CYCLES);

        // three taps: negative clip, clear with ring wrap, positive clip
        write_tap_count(11'd3);
        @(negedge clk);
        queue_word(icv_pkg::FUNC_SAMPLE, 0, 24'h000000, 24'h7FFFFF);
        queue_word(icv_pkg::FUNC_SAMPLE, 0, 24'h000000, 24'h7FFFFF);
        queue_word(icv_pkg::FUNC_SAMPLE, 0, 24'h000000, 24'h7FFFFF);
        queue_word(icv_pkg::FUNC_CLEAR, 0, 24'h000000, 24'h000000);
        queue_word(icv_pkg::FUNC_SAMPLE, 0, 24'h000000, 24'h800000);
        queue_word(icv_pkg::FUNC_SAMPLE, 0, 24'h000000, 24'h000001);
        queue_word(icv_pkg::FUNC_WR_COEF, 1, 24'h7FFFFF, 24'h000000);
        queue_word(icv_pkg::FUNC_SAMPLE, 0, 24'h000000, 24'h7FFFFF);
        wait_for_drain(SETTLE_CYCLES);

        run_phase(11'd0, 1, 1, 70, 1'b0);
        run_phase(11'd2, 0, 2, 70, 1'b0);
        run_phase(11'd7, 2, 0, 70, 1'b0);
        run_phase(11'd16, 1, 2, 70, 1'b0);
        run_phase(11'($urandom_range(1, 40)), 2, 1, 70, 1'b0);
        run_phase(11'd8, 0, 0, 40, 1'b1);
        run_phase(11'd64, 1, 1, 70, 1'b0);
        run_phase(11'd1, 0, 0, 60, 1'b0);

        wait_for_drain(END_CYCLES);
        $display("covered %0d samples, %0d coefficient writes, %0d clears, %0d unused words",
                 n_samples, n_writes, n_clears, n_ignored);
        $display("%0d tap count settings from 0 to 64, %0d clipped outputs, %0d mismatches",
                 tap_settings, n_clipped, errors);
        if (errors == 0 && expected_outputs.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
